/* design/rle8e_pkg.sv */
package rle8e_pkg;

	// Field widths
	localparam int PIXEL_W    = 8;
	localparam int LEN_BYTE_W = PIXEL_W - 1;
	localparam int DIM_W      = 16;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;
	localparam int COUNT_W    = 2;

	// Default packet window in pixels (legal range 3 to 127)
	localparam int MAX_PACKET_DEF = 127;

	// Equal pixels needed to open a run packet
	localparam int RUN_MIN = 3;

	// Index that masked pixels take, also the opaque alpha value
	localparam logic [PIXEL_W-1:0] PIX_MAX = 8'hFF;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_MASK_ENABLE = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_ROW_WIDTH   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_ROW_COUNT   = 2'd2;

	// byte_count codes
	localparam logic [COUNT_W-1:0] BC_ONE = 2'd1;
	localparam logic [COUNT_W-1:0] BC_TWO = 2'd2;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_RUN_A,
		ST_LIT_PRE,
		ST_LIT,
		ST_RUN_C
	} ctrl_state_t;

	// Source of the result loaded into the output register
	typedef enum logic [1:0] {
		SRC_RUN_A,
		SRC_RUN_C,
		SRC_LIT
	} src_t;

	typedef struct packed {
		logic accept;    // pixel transaction taken this cycle
		logic lit_init;  // prime the literal read ports
		logic load;      // load the output register
		src_t src;
	} cmd_t;

	typedef struct packed {
		logic a_emit;    // incoming pixel closes the current run packet
		logic lit_emit;  // incoming pixel causes a literal packet
		logic c_emit;    // incoming pixel flushes a run packet at the end
		logic pend_lit;  // captured: literal packet pending
		logic pend_c;    // captured: closing run packet pending
		logic out_free;  // output register can take a result
		logic lit_last;  // current literal result ends its packet
	} status_t;

endpackage

/* design/rle8e_intf.sv */
interface rle8e_pixel_if;
	logic                             valid;
	logic                             ready;
	logic [rle8e_pkg::PIXEL_W-1:0]    pixel_index;
	logic [rle8e_pkg::PIXEL_W-1:0]    pixel_alpha;

	modport source (output valid, pixel_index, pixel_alpha, input ready);
	modport sink (input valid, pixel_index, pixel_alpha, output ready);
endinterface

interface rle8e_result_if;
	logic                             valid;
	logic                             ready;
	logic [rle8e_pkg::PIXEL_W-1:0]    first_byte;
	logic [rle8e_pkg::PIXEL_W-1:0]    second_byte;
	logic [rle8e_pkg::COUNT_W-1:0]    byte_count;
	logic                             packet_end;
	logic                             image_end;

	modport source (output valid, first_byte, second_byte, byte_count, packet_end, image_end,
		input ready);
	modport sink (input valid, first_byte, second_byte, byte_count, packet_end, image_end,
		output ready);
endinterface

interface rle8e_cfg_if;
	logic                             valid;
	logic                             ready;
	logic [rle8e_pkg::CFG_IDX_W-1:0]  index;
	logic [rle8e_pkg::CFG_DATA_W-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

/* design/rle8_masked_packet_encoder.sv */
// Run-length encoder for 8-bit palette pixels, packets of at most MAX_PACKET pixels.
// pixel:  one pixel transaction per raster position (pixel_index, pixel_alpha).
// result: up to two packet bytes per transaction; packet_end marks the last
//         transaction of a packet, image_end the last one of the image.
// cfg:    register writes (0 mask_enable, 1 row_width, 2 row_count), always ready;
//         write only while no pixel is in flight.
// A pixel that closes no packet leaves the encoder ready for the next pixel. A pixel
//   that closes packets holds the next pixel off until every result it causes is
//   loaded, and the literal store read ports are primed before a literal packet among
//   them is read out; a literal packet of n pixels gives (n + 2) / 2 results, one per
//   cycle from the store's two read ports while the receiver takes them.
// The output register holds the last result, so the next pixel is taken while it
// waits. When the receiver stalls, the result holds and the encoder waits.
// Reset clears the packet state, the row and column counters and the registers
// (masking off, one pixel per row, one row); no result is pending after reset.
module rle8_masked_packet_encoder #(
	parameter int MAX_PACKET = rle8e_pkg::MAX_PACKET_DEF
) (
	input logic      clk,
	input logic      arst_n,
	rle8e_pixel_if.sink    pixel,
	rle8e_result_if.source result,
	rle8e_cfg_if.sink      cfg
);

	rle8e_pkg::cmd_t    cmd;
	rle8e_pkg::status_t st;

	assign cfg.ready = 1'b1;

	rle8e_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (pixel.valid),
		.in_ready (pixel.ready),
		.st       (st),
		.cmd      (cmd)
	);

	rle8e_dp #(
		.MAX_PACKET (MAX_PACKET)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.st          (st),
		.pixel_index (pixel.pixel_index),
		.pixel_alpha (pixel.pixel_alpha),
		.cfg_we      (cfg.valid),
		.cfg_index   (cfg.index),
		.cfg_data    (cfg.data),
		.res_valid   (result.valid),
		.res_ready   (result.ready),
		.first_byte  (result.first_byte),
		.second_byte (result.second_byte),
		.byte_count  (result.byte_count),
		.packet_end  (result.packet_end),
		.image_end   (result.image_end)
	);

endmodule

/* design/rle8e_dp.sv */
module rle8e_dp #(
	parameter int MAX_PACKET = rle8e_pkg::MAX_PACKET_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  rle8e_pkg::cmd_t                   cmd,
	output rle8e_pkg::status_t                st,
	input  logic [rle8e_pkg::PIXEL_W-1:0]     pixel_index,
	input  logic [rle8e_pkg::PIXEL_W-1:0]     pixel_alpha,
	input  logic                              cfg_we,
	input  logic [rle8e_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [rle8e_pkg::CFG_DATA_W-1:0]  cfg_data,
	output logic                              res_valid,
	input  logic                              res_ready,
	output logic [rle8e_pkg::PIXEL_W-1:0]     first_byte,
	output logic [rle8e_pkg::PIXEL_W-1:0]     second_byte,
	output logic [rle8e_pkg::COUNT_W-1:0]     byte_count,
	output logic                              packet_end,
	output logic                              image_end
);

	localparam int LEN_W  = $clog2(MAX_PACKET + 1);
	localparam int ADDR_W = $clog2(MAX_PACKET);
	localparam int DEPTH  = MAX_PACKET;
	localparam int PW     = rle8e_pkg::PIXEL_W;
	localparam int DW     = rle8e_pkg::DIM_W;
	localparam logic [LEN_W-1:0] RUN_MIN_L = LEN_W'(rle8e_pkg::RUN_MIN);
	localparam logic [LEN_W-1:0] POS_MAX   = LEN_W'(MAX_PACKET);
	localparam logic [LEN_W:0]   DEPTH_L   = (LEN_W+1)'(DEPTH);

	// Configuration registers
	logic          mask_q;
	logic [DW-1:0] row_width_q;
	logic [DW-1:0] row_count_q;

	// Packet and raster state
	logic [PW-1:0]    run_val_q;
	logic [LEN_W-1:0] run_len_q;
	logic [LEN_W-1:0] lit_len_q;
	logic [LEN_W-1:0] pos_q;
	logic [DW-1:0]    col_q;
	logic [DW-1:0]    row_q;

	// Captured packet descriptors
	logic [LEN_W-1:0] a_len_q;
	logic [PW-1:0]    a_val_q;
	logic [LEN_W-1:0] c_len_q;
	logic [PW-1:0]    c_val_q;
	logic             c_img_q;
	logic [LEN_W-1:0] lit_count_q;
	logic             lit_img_q;
	logic             pend_lit_q;
	logic             pend_c_q;

	// Literal readout
	logic [LEN_W-1:0]  bi_q;
	logic [PW-1:0]     rd_a_q;
	logic [PW-1:0]     rd_b_q;
	logic [PW-1:0]     store_mem [DEPTH];

	// Output register
	logic                           out_valid_q;
	logic [PW-1:0]                  first_q;
	logic [PW-1:0]                  second_q;
	logic [rle8e_pkg::COUNT_W-1:0]  count_q;
	logic                           pend_q;
	logic                           img_q;

	// Step logic
	logic [PW-1:0]    eff;
	logic             run_mode;
	logic             run_mode1;
	logic             a_emit;
	logic [LEN_W-1:0] rl0, ll0, pp0;
	logic [PW-1:0]    rv0;
	logic [LEN_W-1:0] rl1, ll1, pp1;
	logic [PW-1:0]    rv1;
	logic [LEN_W-1:0] ll_inc;
	logic [LEN_W-1:0] rl_lit;
	logic             trig;
	logic             b_emit;
	logic [LEN_W-1:0] b_count;
	logic [DW:0]      col_next;
	logic [DW:0]      row_next;
	logic             row_end;
	logic             img_end;
	logic             flush;
	logic             c_run;
	logic             c_lit;

	logic              we;
	logic [ADDR_W-1:0] waddr;
	logic              lit_adv;
	logic [LEN_W:0]    bi_plus1;
	logic [LEN_W:0]    bi_plus2;
	logic              re_a;
	logic              re_b;
	logic [ADDR_W-1:0] addr_a;
	logic [ADDR_W-1:0] addr_b;
	logic              lit_last;
	logic              lit_two;
	logic              out_free;

	logic [PW-1:0]                 nx_first;
	logic [PW-1:0]                 nx_second;
	logic [rle8e_pkg::COUNT_W-1:0] nx_count;
	logic                          nx_pend;
	logic                          nx_img;

	// Configuration writes; unknown indexes are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mask_q      <= 1'b0;
			row_width_q <= DW'(1);
			row_count_q <= DW'(1);
		end else if (cfg_we) begin
			unique case (cfg_index)
				rle8e_pkg::CFG_MASK_ENABLE: mask_q      <= cfg_data[0];
				rle8e_pkg::CFG_ROW_WIDTH:   row_width_q <= cfg_data[DW-1:0];
				rle8e_pkg::CFG_ROW_COUNT:   row_count_q <= cfg_data[DW-1:0];
				default: ;
			endcase
		end
	end

	// Per-pixel packet decision
	always_comb begin
		eff = (mask_q && pixel_alpha != rle8e_pkg::PIX_MAX) ? rle8e_pkg::PIX_MAX : pixel_index;
		run_mode = run_len_q >= RUN_MIN_L;
		a_emit   = run_mode && (eff != run_val_q);

		// a run broken by this pixel closes and a new packet opens
		rl0 = a_emit ? '0 : run_len_q;
		rv0 = a_emit ? '0 : run_val_q;
		ll0 = a_emit ? '0 : lit_len_q;
		pp0 = a_emit ? '0 : pos_q;
		run_mode1 = run_mode && !a_emit;

		ll_inc  = ll0 + LEN_W'(1);
		rl_lit  = (rl0 != '0 && eff == rv0) ? rl0 + LEN_W'(1) : LEN_W'(1);
		trig    = !run_mode1 && (rl_lit >= RUN_MIN_L);
		b_emit  = trig && (ll_inc > RUN_MIN_L);
		b_count = ll_inc - RUN_MIN_L;

		if (run_mode1) begin
			rl1 = rl0 + LEN_W'(1);
			rv1 = rv0;
			ll1 = ll0;
			pp1 = pp0 + LEN_W'(1);
		end else begin
			rl1 = rl_lit;
			rv1 = (rl0 != '0 && eff == rv0) ? rv0 : eff;
			ll1 = trig ? '0 : ll_inc;
			pp1 = trig ? RUN_MIN_L : pp0 + LEN_W'(1);
		end

		col_next = {1'b0, col_q} + (DW+1)'(1);
		row_next = {1'b0, row_q} + (DW+1)'(1);
		row_end  = col_next >= {1'b0, row_width_q};
		img_end  = row_end && (row_next >= {1'b0, row_count_q});

		flush = row_end || (pp1 >= POS_MAX);
		c_run = flush && (rl1 >= RUN_MIN_L);
		c_lit = flush && (rl1 < RUN_MIN_L);

		we    = cmd.accept && !run_mode1;
		waddr = ll0[ADDR_W-1:0];
	end

	// Packet and raster state update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_val_q  <= '0;
			run_len_q  <= '0;
			lit_len_q  <= '0;
			pos_q      <= '0;
			col_q      <= '0;
			row_q      <= '0;
			pend_lit_q <= 1'b0;
			pend_c_q   <= 1'b0;
		end else if (cmd.accept) begin
			if (flush) begin
				run_val_q <= '0;
				run_len_q <= '0;
				lit_len_q <= '0;
				pos_q     <= '0;
			end else begin
				run_val_q <= rv1;
				run_len_q <= rl1;
				lit_len_q <= ll1;
				pos_q     <= pp1;
			end
			if (row_end) begin
				col_q <= '0;
				row_q <= img_end ? '0 : row_next[DW-1:0];
			end else begin
				col_q <= col_next[DW-1:0];
			end
			pend_lit_q <= b_emit || c_lit;
			pend_c_q   <= c_run;
		end
	end

	// Descriptors of the packets this pixel releases
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			a_len_q     <= run_len_q;
			a_val_q     <= run_val_q;
			c_len_q     <= rl1;
			c_val_q     <= rv1;
			c_img_q     <= img_end;
			lit_count_q <= b_emit ? b_count : ll1;
			lit_img_q   <= c_lit && img_end;
		end
	end

	// Literal readout addressing, two store entries per result
	always_comb begin
		bi_plus1 = {1'b0, bi_q} + (LEN_W+1)'(1);
		bi_plus2 = {1'b0, bi_q} + (LEN_W+1)'(2);
		lit_last = bi_plus1 >= {1'b0, lit_count_q};
		lit_two  = bi_q < lit_count_q;
		lit_adv  = cmd.load && (cmd.src == rle8e_pkg::SRC_LIT) && !lit_last;
		re_a     = lit_adv;
		addr_a   = bi_plus1[ADDR_W-1:0];
		re_b     = cmd.lit_init || (lit_adv && bi_plus2 < DEPTH_L);
		addr_b   = cmd.lit_init ? '0 : bi_plus2[ADDR_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bi_q <= '0;
		end else if (cmd.lit_init) begin
			bi_q <= '0;
		end else if (lit_adv) begin
			bi_q <= bi_plus2[LEN_W-1:0];
		end
	end

	// Literal store: one write port, two registered read ports
	always_ff @(posedge clk) begin
		if (we) begin
			store_mem[waddr] <= eff;
		end
		if (re_a) begin
			rd_a_q <= store_mem[addr_a];
		end
		if (re_b) begin
			rd_b_q <= store_mem[addr_b];
		end
	end

	// Result selection
	always_comb begin
		nx_first  = '0;
		nx_second = '0;
		nx_count  = rle8e_pkg::BC_TWO;
		nx_pend   = 1'b1;
		nx_img    = 1'b0;
		unique case (cmd.src)
			rle8e_pkg::SRC_RUN_A: begin
				nx_first  = {1'b0, rle8e_pkg::LEN_BYTE_W'(a_len_q)};
				nx_second = a_val_q;
			end
			rle8e_pkg::SRC_RUN_C: begin
				nx_first  = {1'b0, rle8e_pkg::LEN_BYTE_W'(c_len_q)};
				nx_second = c_val_q;
				nx_img    = c_img_q;
			end
			rle8e_pkg::SRC_LIT: begin
				nx_first  = (bi_q == '0) ? {1'b1, rle8e_pkg::LEN_BYTE_W'(lit_count_q)} : rd_a_q;
				nx_second = lit_two ? rd_b_q : '0;
				nx_count  = lit_two ? rle8e_pkg::BC_TWO : rle8e_pkg::BC_ONE;
				nx_pend   = lit_last;
				nx_img    = lit_last && lit_img_q;
			end
			default: begin
				nx_count = rle8e_pkg::BC_ONE;
				nx_pend  = 1'b0;
			end
		endcase
	end

	// Output register
	assign out_free = !out_valid_q || res_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load) begin
			out_valid_q <= 1'b1;
		end else if (res_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			first_q  <= nx_first;
			second_q <= nx_second;
			count_q  <= nx_count;
			pend_q   <= nx_pend;
			img_q    <= nx_img;
		end
	end

	assign res_valid   = out_valid_q;
	assign first_byte  = first_q;
	assign second_byte = second_q;
	assign byte_count  = count_q;
	assign packet_end  = pend_q;
	assign image_end   = img_q;

	// Status to the controller
	always_comb begin
		st.a_emit   = a_emit;
		st.lit_emit = b_emit || c_lit;
		st.c_emit   = c_run;
		st.pend_lit = pend_lit_q;
		st.pend_c   = pend_c_q;
		st.out_free = out_free;
		st.lit_last = lit_last;
	end

	// Checks
	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |-> out_free)
		else $error("result loaded over an untaken result");

	a_pos_window: assert property (@(posedge clk) disable iff (!arst_n)
		pos_q < POS_MAX)
		else $error("packet position reached the window without a flush");

	a_run_in_pkt: assert property (@(posedge clk) disable iff (!arst_n)
		run_len_q <= pos_q)
		else $error("run longer than its packet");

	a_lit_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.lit_init |-> (lit_count_q != '0))
		else $error("empty literal packet started");

endmodule

/* design/rle8e_ctrl.sv */
module rle8e_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  rle8e_pkg::status_t st,
	output rle8e_pkg::cmd_t    cmd
);

	rle8e_pkg::ctrl_state_t state_q;
	rle8e_pkg::ctrl_state_t state_d;

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= rle8e_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and commands
	always_comb begin
		state_d      = state_q;
		in_ready     = 1'b0;
		cmd.accept   = 1'b0;
		cmd.lit_init = 1'b0;
		cmd.load     = 1'b0;
		cmd.src      = rle8e_pkg::SRC_LIT;
		unique case (state_q)
			rle8e_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.accept = 1'b1;
					if (st.a_emit) begin
						state_d = rle8e_pkg::ST_RUN_A;
					end else if (st.lit_emit) begin
						state_d = rle8e_pkg::ST_LIT_PRE;
					end else if (st.c_emit) begin
						state_d = rle8e_pkg::ST_RUN_C;
					end
				end
			end
			rle8e_pkg::ST_RUN_A: begin
				cmd.src = rle8e_pkg::SRC_RUN_A;
				if (st.out_free) begin
					cmd.load = 1'b1;
					if (st.pend_lit) begin
						state_d = rle8e_pkg::ST_LIT_PRE;
					end else if (st.pend_c) begin
						state_d = rle8e_pkg::ST_RUN_C;
					end else begin
						state_d = rle8e_pkg::ST_IDLE;
					end
				end
			end
			rle8e_pkg::ST_LIT_PRE: begin
				cmd.lit_init = 1'b1;
				state_d      = rle8e_pkg::ST_LIT;
			end
			rle8e_pkg::ST_LIT: begin
				cmd.src = rle8e_pkg::SRC_LIT;
				if (st.out_free) begin
					cmd.load = 1'b1;
					if (st.lit_last) begin
						state_d = st.pend_c ? rle8e_pkg::ST_RUN_C : rle8e_pkg::ST_IDLE;
					end
				end
			end
			rle8e_pkg::ST_RUN_C: begin
				cmd.src = rle8e_pkg::SRC_RUN_C;
				if (st.out_free) begin
					cmd.load = 1'b1;
					state_d  = rle8e_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = rle8e_pkg::ST_IDLE;
			end
		endcase
	end

endmodule
